@@ rtl/lsfe_pkg.sv @@
package lsfe_pkg;

    // field widths
    localparam int LenBits  = 32;
    localparam int ByteBits = 8;
    localparam int PosW     = $clog2(LenBits);

    // parse phases
    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_EXTLEN = 3'd1;
    localparam logic [2:0] PH_DOT    = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_PAYLEN = 3'd4;
    localparam logic [2:0] PH_PAY    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_HALT   = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_EXT = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_ZERO_EXT   = 3'd2;
    localparam logic [2:0] ERR_MISSING_DOT = 3'd3;
    localparam logic [2:0] ERR_ZERO_PAY   = 3'd4;

    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] MAGIC_RESET = 8'd35;

    // one registered input word, only the hidden bit is kept
    typedef struct packed {
        logic data_bit;
        logic frame_start;
    } t_item;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
        logic [2:0] error_code;
    } t_result;

endpackage

@@ rtl/lsfe_item_if.sv @@
interface lsfe_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] carrier_byte;
    logic       frame_start;

    modport source (output valid, output carrier_byte, output frame_start, input ready);
    modport sink   (input valid, input carrier_byte, input frame_start, output ready);
endinterface

@@ rtl/lsfe_result_if.sv @@
interface lsfe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
    logic [2:0] error_code;

    modport source (output valid, output out_byte, output kind, output last,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input kind, input last,
                    input error_code, output ready);
endinterface

@@ rtl/lsfe_cfg_if.sv @@
interface lsfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] magic_byte;

    modport source (output valid, output magic_byte, input ready);
    modport sink   (input valid, input magic_byte, output ready);
endinterface

@@ rtl/lsfe_in_reg.sv @@
module lsfe_in_reg
    import lsfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_adv,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_vld;
    t_item r_item;

    // slot frees when the parser consumes the word
    assign o_ready = !r_vld || i_adv;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/lsfe_parser.sv @@
module lsfe_parser
    import lsfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_item        i_item,
    input  logic         i_step,
    input  logic [7:0]   i_magic,
    output logic         o_res_vld,
    output t_result      o_res
);

    logic [2:0]         r_phase, n_phase;
    logic [PosW-1:0]    r_pos, n_pos;
    logic [LenBits-1:0] r_acc, n_acc;
    logic [LenBits-1:0] r_rem, n_rem;

    logic [2:0]         cur_phase;
    logic [PosW-1:0]    cur_pos;
    logic [LenBits-1:0] cur_acc;
    logic [LenBits-1:0] cur_rem;
    logic [LenBits-1:0] value;
    logic               is_len;
    logic               field_done;
    logic               is_last;

    // frame_start restarts parsing with this word's bit
    always_comb begin
        cur_phase = i_item.frame_start ? PH_MAGIC : r_phase;
        cur_pos   = i_item.frame_start ? '0 : r_pos;
        cur_acc   = i_item.frame_start ? '0 : r_acc;
        cur_rem   = i_item.frame_start ? '0 : r_rem;
        value     = {cur_acc[LenBits-2:0], i_item.data_bit};
        is_len    = (cur_phase == PH_EXTLEN) || (cur_phase == PH_PAYLEN);
        field_done = is_len ? (cur_pos == PosW'(LenBits - 1))
                            : (cur_pos == PosW'(ByteBits - 1));
        is_last   = (cur_rem == LenBits'(1));
    end

    // field completion and phase sequencing
    always_comb begin
        n_phase   = cur_phase;
        n_pos     = cur_pos + 1'b1;
        n_acc     = value;
        n_rem     = cur_rem;
        o_res_vld = 1'b0;
        o_res     = '0;
        if ((cur_phase == PH_DONE) || (cur_phase == PH_HALT)) begin
            n_pos = cur_pos;
            n_acc = cur_acc;
        end else if (field_done) begin
            n_pos = '0;
            n_acc = '0;
            unique case (cur_phase)
                PH_MAGIC: begin
                    if (value[7:0] != i_magic) begin
                        n_phase          = PH_HALT;
                        o_res_vld        = 1'b1;
                        o_res.kind       = KIND_ERR;
                        o_res.error_code = ERR_BAD_MAGIC;
                    end else begin
                        n_phase = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    if (value == '0) begin
                        n_phase          = PH_HALT;
                        o_res_vld        = 1'b1;
                        o_res.kind       = KIND_ERR;
                        o_res.error_code = ERR_ZERO_EXT;
                    end else begin
                        n_rem   = value;
                        n_phase = PH_DOT;
                    end
                end
                PH_DOT: begin
                    if (value[7:0] != DOT_CHAR) begin
                        n_phase          = PH_HALT;
                        o_res_vld        = 1'b1;
                        o_res.kind       = KIND_ERR;
                        o_res.error_code = ERR_MISSING_DOT;
                    end else begin
                        n_phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    n_rem          = cur_rem - LenBits'(1);
                    o_res_vld      = 1'b1;
                    o_res.out_byte = value[7:0];
                    o_res.kind     = KIND_EXT;
                    o_res.last     = is_last;
                    if (is_last) begin
                        n_phase = PH_PAYLEN;
                    end
                end
                PH_PAYLEN: begin
                    if (value == '0) begin
                        n_phase          = PH_HALT;
                        o_res_vld        = 1'b1;
                        o_res.kind       = KIND_ERR;
                        o_res.error_code = ERR_ZERO_PAY;
                    end else begin
                        n_rem   = value;
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY: begin
                    n_rem          = cur_rem - LenBits'(1);
                    o_res_vld      = 1'b1;
                    o_res.out_byte = value[7:0];
                    o_res.kind     = KIND_PAY;
                    o_res.last     = is_last;
                    if (is_last) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = cur_phase;
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ rtl/lsfe_out_reg.sv @@
module lsfe_out_reg
    import lsfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    // slot is free when empty or being taken this cycle
    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/lsb_stego_frame_extractor.sv @@
// channel    | dir | handshake     | payload
// i_item     | in  | valid / ready | carrier_byte, frame_start
// o_result   | out | valid / ready | out_byte, kind, last, error_code
// i_cfg      | in  | valid / ready | magic_byte (always ready)
//
// one word per cycle sustained unless a held result stalls it; a word goes input
// register -> parser (combinational) -> output register, where its result is held.
// the parser's field step (shift, 32-bit zero test, decrement) sets the rate.
// a held result stalls only words that produce a result; others keep flowing.
// synchronous active-low reset returns to the magic phase with magic_byte = 35.
module lsb_stego_frame_extractor
    import lsfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsfe_item_if.sink     i_item,
    lsfe_cfg_if.sink      i_cfg,
    lsfe_result_if.source o_result
);

    logic [7:0] r_magic_byte;
    t_item      item_in;
    t_item      item_q;
    logic       item_vld;
    logic       adv;
    logic       res_vld;
    t_result    res;
    logic       out_free;
    t_result    out_res;

    // magic register, written any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_byte <= MAGIC_RESET;
        end else if (i_cfg.valid) begin
            r_magic_byte <= i_cfg.magic_byte;
        end
    end

    // input word, only bit 0 carries data
    assign item_in.data_bit    = i_item.carrier_byte[0];
    assign item_in.frame_start = i_item.frame_start;

    // advance when the word gives no result or the output slot is free
    assign adv = item_vld && (!res_vld || out_free);

    lsfe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_item  (item_in),
        .i_adv   (adv),
        .o_ready (i_item.ready),
        .o_valid (item_vld),
        .o_item  (item_q)
    );

    lsfe_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_q),
        .i_step    (adv),
        .i_magic   (r_magic_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    lsfe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_vld),
        .i_res   (res),
        .i_ready (o_result.ready),
        .o_free  (out_free),
        .o_valid (o_result.valid),
        .o_res   (out_res)
    );

    // result word to the port
    assign o_result.out_byte   = out_res.out_byte;
    assign o_result.kind       = out_res.kind;
    assign o_result.last       = out_res.last;
    assign o_result.error_code = out_res.error_code;

endmodule

@@ rtl/lsfe_checker.sv @@
module lsfe_checker
    import lsfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_kind,
    input logic       i_last,
    input logic [2:0] i_error_code
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_kind) && $stable(i_last) && $stable(i_error_code))
        else $error("result changed while stalled");

    // error reports carry a code and nothing else
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_ERR) |->
            (i_out_byte == 8'd0) && !i_last && (i_error_code != ERR_NONE)
            && (i_error_code <= ERR_ZERO_PAY))
        else $error("malformed error report");

    // data words carry no error code
    a_data_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != KIND_ERR) |-> (i_error_code == ERR_NONE))
        else $error("data word with error code");

    // kind stays in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_EXT) || (i_kind == KIND_PAY)
            || (i_kind == KIND_ERR))
        else $error("undefined result kind");

endmodule

bind lsb_stego_frame_extractor lsfe_checker u_lsfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_byte   (o_result.out_byte),
    .i_kind       (o_result.kind),
    .i_last       (o_result.last),
    .i_error_code (o_result.error_code)
);

@@ tb/sv/testbench.sv @@
module testbench;
    import lsfe_pkg::*;

    localparam int        QUIET_LIMIT = 2000;
    localparam t_result   NO_WORD     = '0;

    // one directed frame: which parts go out, what they hold, and the
    // error word to expect where it is plain from the frame itself
    typedef struct {
        logic        start;
        logic [7:0]  sig;
        logic [31:0] ext_len;
        logic [7:0]  dot;
        int          ext_cnt;
        logic [31:0] pay_len;
        int          pay_cnt;
        int          fill;
        int          parts;
        int          tail;
        logic        typed;
        t_result     want;
    } t_case;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsfe_item_if   item_bus ();
    lsfe_cfg_if    cfg_bus ();
    lsfe_result_if result_bus ();

    lsb_stego_frame_extractor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // start, sig, ext_len, dot, ext_cnt, pay_len, pay_cnt, fill, parts, tail, typed, want
    // fill < 0 means random data bytes
    t_case directed_cases [10] = '{
        // straight after reset, zero data bytes, words after the frame ignored
        '{1'b0, MAGIC_RESET, 32'd1, DOT_CHAR, 1, 32'd1, 1, 0, 6, 6, 1'b0, NO_WORD},
        '{1'b1, 8'h00, 32'd1, DOT_CHAR, 1, 32'd1, 1, -1, 1, 3, 1'b1,
          '{8'h00, KIND_ERR, 1'b0, ERR_BAD_MAGIC}},
        '{1'b1, 8'hFF, 32'd1, DOT_CHAR, 1, 32'd1, 1, -1, 1, 2, 1'b1,
          '{8'h00, KIND_ERR, 1'b0, ERR_BAD_MAGIC}},
        '{1'b1, MAGIC_RESET, 32'd0, DOT_CHAR, 1, 32'd1, 1, -1, 2, 3, 1'b1,
          '{8'h00, KIND_ERR, 1'b0, ERR_ZERO_EXT}},
        '{1'b1, MAGIC_RESET, 32'd1, 8'h2F, 1, 32'd1, 1, -1, 3, 2, 1'b1,
          '{8'h00, KIND_ERR, 1'b0, ERR_MISSING_DOT}},
        '{1'b1, MAGIC_RESET, 32'd2, DOT_CHAR, 2, 32'd0, 1, 255, 5, 2, 1'b1,
          '{8'h00, KIND_ERR, 1'b0, ERR_ZERO_PAY}},
        // length with only its top bit set, cut off and restarted by the next frame
        '{1'b1, MAGIC_RESET, 32'h8000_0000, DOT_CHAR, 3, 32'd1, 1, -1, 4, 0, 1'b0, NO_WORD},
        '{1'b1, MAGIC_RESET, 32'd1, DOT_CHAR, 1, 32'h0100_0000, 3, -1, 6, 0, 1'b0, NO_WORD},
        '{1'b1, MAGIC_RESET, 32'd3, DOT_CHAR, 3, 32'd4, 4, 255, 6, 4, 1'b0, NO_WORD},
        '{1'b1, MAGIC_RESET, 32'd4, DOT_CHAR, 4, 32'd6, 6, -1, 6, 0, 1'b0, NO_WORD}
    };

    // extractor state as predicted
    logic [2:0]  frame_phase = PH_MAGIC;
    int          bits_held   = 0;
    logic [31:0] shift_acc   = '0;
    logic [31:0] bytes_left  = '0;
    logic [7:0]  magic_sig   = MAGIC_RESET;

    t_result extracted_words [$];
    t_result last_word;
    int      words_seen     = 0;
    int      items_sent     = 0;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      tx_gap_pct     = 36;
    int      rx_stall_pct   = 68;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_word(input t_result got, input t_result want);
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, want.error_code));
    endtask

    function automatic logic halt_frame(input logic [2:0] code, output t_result word);
        frame_phase = PH_HALT;
        word = '{out_byte: 8'h00, kind: KIND_ERR, last: 1'b0, error_code: code};
        return 1'b1;
    endfunction

    // advance the parser by one carrier word; returns 1 when it yields a word
    function automatic logic extract_hidden_bit(input logic [7:0] carrier, input logic start,
                                                output t_result word);
        logic [31:0] field;
        int          need;
        word = NO_WORD;
        if (start) begin
            frame_phase = PH_MAGIC;
            bits_held   = 0;
            shift_acc   = '0;
            bytes_left  = '0;
        end
        if (frame_phase == PH_DONE || frame_phase == PH_HALT)
            return 1'b0;

        // gather msb first until the current field is full
        shift_acc = {shift_acc[LenBits-2:0], carrier[0]};
        bits_held++;
        need = (frame_phase == PH_EXTLEN || frame_phase == PH_PAYLEN) ? LenBits : ByteBits;
        if (bits_held < need)
            return 1'b0;
        field     = shift_acc;
        shift_acc = '0;
        bits_held = 0;

        case (frame_phase)
            PH_MAGIC: begin
                if (field[7:0] != magic_sig)
                    return halt_frame(ERR_BAD_MAGIC, word);
                frame_phase = PH_EXTLEN;
            end
            PH_EXTLEN: begin
                if (field == '0)
                    return halt_frame(ERR_ZERO_EXT, word);
                bytes_left  = field;
                frame_phase = PH_DOT;
            end
            PH_DOT: begin
                if (field[7:0] != DOT_CHAR)
                    return halt_frame(ERR_MISSING_DOT, word);
                frame_phase = PH_EXT;
            end
            PH_EXT: begin
                bytes_left--;
                word = '{out_byte: field[7:0], kind: KIND_EXT, last: (bytes_left == '0),
                         error_code: ERR_NONE};
                if (bytes_left == '0)
                    frame_phase = PH_PAYLEN;
                return 1'b1;
            end
            PH_PAYLEN: begin
                if (field == '0)
                    return halt_frame(ERR_ZERO_PAY, word);
                bytes_left  = field;
                frame_phase = PH_PAY;
            end
            PH_PAY: begin
                bytes_left--;
                word = '{out_byte: field[7:0], kind: KIND_PAY, last: (bytes_left == '0),
                         error_code: ERR_NONE};
                if (bytes_left == '0)
                    frame_phase = PH_DONE;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // result check first, then register write, then prediction of the accepted word
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                got = '{out_byte: result_bus.out_byte, kind: result_bus.kind,
                        last: result_bus.last, error_code: result_bus.error_code};
                last_word = got;
                words_seen++;
                if (extracted_words.size() == 0)
                    report_mismatch($sformatf("result word %h with nothing expected", got));
                else begin
                    want = extracted_words.pop_front();
                    compare_word(got, want);
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
                magic_sig = cfg_bus.magic_byte;
            if (item_bus.valid && item_bus.ready) begin
                if (extract_hidden_bit(item_bus.carrier_byte, item_bus.frame_start, want))
                    extracted_words.push_back(want);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one carrier word, with random sender gaps in front
    task automatic send_item(input logic [7:0] carrier, input logic start, input logic counted);
        if ($urandom_range(99) < tx_gap_pct) begin
            item_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        item_bus.valid        <= 1'b1;
        item_bus.carrier_byte <= carrier;
        item_bus.frame_start  <= start;
        do @(posedge i_clk); while (!(item_bus.valid && item_bus.ready));
        if (counted)
            items_sent++;
    endtask

    // hide a field msb first in the low bits of random carrier words
    task automatic send_field(input logic [31:0] value, input int width, input logic start);
        logic [7:0] carrier;
        for (int b = width - 1; b >= 0; b--) begin
            carrier    = 8'($urandom_range(255));
            carrier[0] = value[b];
            send_item(carrier, start && (b == width - 1), 1'b1);
        end
    endtask

    function automatic logic [7:0] data_byte(input int fill);
        return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
    endfunction

    task automatic send_frame(input logic start, input logic [7:0] sig,
                              input logic [31:0] ext_len, input logic [7:0] dot,
                              input int ext_cnt, input logic [31:0] pay_len,
                              input int pay_cnt, input int fill, input int parts,
                              input int tail);
        send_field(sig, ByteBits, start);
        if (parts > 1)
            send_field(ext_len, LenBits, 1'b0);
        if (parts > 2)
            send_field(dot, ByteBits, 1'b0);
        if (parts > 3)
            repeat (ext_cnt) send_field(data_byte(fill), ByteBits, 1'b0);
        if (parts > 4)
            send_field(pay_len, LenBits, 1'b0);
        if (parts > 5)
            repeat (pay_cnt) send_field(data_byte(fill), ByteBits, 1'b0);
        // words past the end of a frame or a halt are ignored
        repeat (tail) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    // mostly good frames, some broken or cut short, some raw noise
    task automatic send_random_frame();
        int          pick;
        int          ext_n;
        int          pay_n;
        int          parts;
        logic [7:0]  sig;
        logic [7:0]  dot;
        logic [31:0] ext_len;
        logic [31:0] pay_len;
        pick    = $urandom_range(99);
        ext_n   = $urandom_range(4, 1);
        pay_n   = $urandom_range(8, 1);
        sig     = magic_sig;
        dot     = DOT_CHAR;
        ext_len = ext_n;
        pay_len = pay_n;
        parts   = 6;
        if (pick >= 90) begin
            repeat ($urandom_range(40, 4))
                send_item(8'($urandom_range(255)), ($urandom_range(99) < 5), 1'b1);
        end else begin
            if (pick >= 84) begin
                pay_len = '0;
                parts   = 5;
            end else if (pick >= 78) begin
                dot   = dot ^ 8'($urandom_range(255, 1));
                parts = 3;
            end else if (pick >= 72) begin
                ext_len = '0;
                parts   = 2;
            end else if (pick >= 65) begin
                sig   = sig ^ 8'($urandom_range(255, 1));
                parts = 1;
            end else if (pick >= 58) begin
                // payload cut short, the next frame restarts the parser
                pay_n = $urandom_range(pay_n - 1, 0);
            end
            send_frame(1'b1, sig, ext_len, dot, ext_n, pay_len, pay_n, -1, parts,
                       $urandom_range(3, 0));
        end
    endtask

    // drop valid, let every expected word arrive, then cover the pipeline latency
    task automatic settle_block();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (extracted_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_magic(input logic [7:0] sig);
        settle_block();
        cfg_bus.magic_byte <= sig;
        cfg_bus.valid      <= 1'b1;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_random(input logic [7:0] sig, input int gap_pct, input int stall_pct,
                              input int quota);
        int stop_at;
        write_magic(sig);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        stop_at      = items_sent + quota;
        while (items_sent < stop_at) send_random_frame();
    endtask

    initial begin
        int seen_before;
        i_rst_n               = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.carrier_byte = '0;
        item_bus.frame_start  = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.magic_byte    = '0;
        result_bus.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames under the reset signature
        foreach (directed_cases[i]) begin
            seen_before = words_seen;
            send_frame(directed_cases[i].start, directed_cases[i].sig,
                       directed_cases[i].ext_len, directed_cases[i].dot,
                       directed_cases[i].ext_cnt, directed_cases[i].pay_len,
                       directed_cases[i].pay_cnt, directed_cases[i].fill,
                       directed_cases[i].parts, directed_cases[i].tail);
            if (directed_cases[i].typed) begin
                settle_block();
                if (words_seen == seen_before)
                    report_mismatch($sformatf("frame %0d gave no error word", i));
                else
                    compare_word(last_word, directed_cases[i].want);
            end
        end

        // random frames under the signature extremes and one value between
        run_random(8'h00, 36, 68, 150);
        run_random(8'hFF, 68, 36, 150);
        run_random(8'($urandom_range(254, 1)), 0, 0, 150);

        settle_block();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && extracted_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
